>>> design/tbfe_pkg.sv
package tbfe_pkg;

  localparam int MAX_TETS   = 1024;
  localparam int MAX_VERTS  = 1024;
  localparam int VID_W      = 10;
  localparam int TET_AW     = $clog2(MAX_TETS);
  localparam int CNT_W      = TET_AW + 1;
  localparam int SVC_W      = $clog2(MAX_VERTS) + 1;
  localparam int VID_SPACE  = 1 << VID_W;
  localparam int FACE_SLOTS = 8 * MAX_TETS;
  localparam int FSLOT_W    = $clog2(FACE_SLOTS);
  localparam int KEY_W      = 3 * VID_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_TET_WR,
    OP_TET_LAT,
    OP_KEY,
    OP_PNEXT,
    OP_PINS,
    OP_NEXT_FACE,
    OP_NEXT_ROT,
    OP_MAP_UPD,
    OP_PUSH,
    OP_FINAL,
    OP_ACK
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] ack;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic scan_empty;
    logic slot_empty;
    logic slot_hit;
    logic face_last;
    logic rot_last;
    logic corner_last;
    logic pend;
    logic out_busy;
    logic clr_done;
  } dp_sts_t;

  // corner k of outward face f
  function automatic logic [1:0] face_corner(input logic [1:0] f, input logic [1:0] k);
    logic [5:0] row;
    unique case (f)
      2'd0:    row = {2'd1, 2'd2, 2'd0};
      2'd1:    row = {2'd2, 2'd3, 2'd0};
      2'd2:    row = {2'd3, 2'd1, 2'd0};
      default: row = {2'd3, 2'd2, 2'd1};
    endcase
    unique case (k)
      2'd0:    return row[1:0];
      2'd1:    return row[3:2];
      default: return row[5:4];
    endcase
  endfunction

  // fold a face key into a home slot
  function automatic logic [FSLOT_W-1:0] face_home(input logic [KEY_W-1:0] key);
    logic [3*FSLOT_W-1:0] ext;
    ext = (3*FSLOT_W)'(key);
    return ext[FSLOT_W-1:0] ^ ext[2*FSLOT_W-1:FSLOT_W] ^ ext[3*FSLOT_W-1:2*FSLOT_W];
  endfunction

endpackage

>>> design/tbfe_ctrl.sv
module tbfe_ctrl import tbfe_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_RCLR = 13'b0000000000001,
    ST_IDLE = 13'b0000000000010,
    ST_DISP = 13'b0000000000100,
    ST_CCLR = 13'b0000000001000,
    ST_ACK  = 13'b0000000010000,
    ST_TRD  = 13'b0000000100000,
    ST_KEY  = 13'b0000001000000,
    ST_PRD  = 13'b0000010000000,
    ST_PCMP = 13'b0000100000000,
    ST_PUSH = 13'b0001000000000,
    ST_MRD  = 13'b0010000000000,
    ST_MUPD = 13'b0100000000000,
    ST_END  = 13'b1000000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] ack_r, ack_nxt;

  assign in_stall = (state_r != ST_IDLE);

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    ack_nxt   = ack_r;
    cmd.op    = OP_NONE;
    cmd.ack   = ack_r;
    unique case (state_r)
      ST_RCLR: begin
        cmd.op = OP_CLR_STEP;
        if (sts.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts.cmd)
          CMD_CLEAR: begin
            cmd.op    = OP_CLR_INIT;
            ack_nxt   = STS_OK;
            state_nxt = ST_CCLR;
          end
          CMD_LOAD: begin
            if (sts.full) begin
              ack_nxt   = STS_FULL;
              state_nxt = ST_ACK;
            end else begin
              cmd.op    = OP_TET_WR;
              state_nxt = ST_KEY;
            end
          end
          CMD_SCAN: begin
            if (sts.scan_empty) begin
              ack_nxt   = STS_EMPTY;
              state_nxt = ST_ACK;
            end else begin
              state_nxt = ST_TRD;
            end
          end
          default: begin
            ack_nxt   = STS_OK;
            state_nxt = ST_ACK;
          end
        endcase
      end
      ST_CCLR: begin
        cmd.op = OP_CLR_STEP;
        if (sts.clr_done) state_nxt = ST_ACK;
      end
      ST_ACK: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_ACK;
          state_nxt = ST_IDLE;
        end
      end
      ST_TRD: begin
        cmd.op    = OP_TET_LAT;
        state_nxt = ST_KEY;
      end
      ST_KEY: begin
        cmd.op    = OP_KEY;
        state_nxt = ST_PRD;
      end
      ST_PRD: state_nxt = ST_PCMP;
      ST_PCMP: begin
        if (sts.cmd == CMD_LOAD) begin
          // insert pass: stop at the key or at a free slot
          priority if (sts.slot_empty) begin
            cmd.op    = OP_PINS;
            ack_nxt   = STS_OK;
            state_nxt = sts.face_last ? ST_ACK : ST_KEY;
          end else if (sts.slot_hit) begin
            cmd.op    = OP_NEXT_FACE;
            ack_nxt   = STS_OK;
            state_nxt = sts.face_last ? ST_ACK : ST_KEY;
          end else begin
            cmd.op    = OP_PNEXT;
            state_nxt = ST_PRD;
          end
        end else begin
          // lookup pass: any rotation present means an inner face
          priority if (sts.slot_empty) begin
            if (sts.rot_last) begin
              state_nxt = ST_PUSH;
            end else begin
              cmd.op    = OP_NEXT_ROT;
              state_nxt = ST_KEY;
            end
          end else if (sts.slot_hit) begin
            cmd.op    = OP_NEXT_FACE;
            state_nxt = sts.face_last ? ST_END : ST_KEY;
          end else begin
            cmd.op    = OP_PNEXT;
            state_nxt = ST_PRD;
          end
        end
      end
      ST_PUSH: begin
        // send the held face out before building the next one
        if (!sts.out_busy) begin
          if (sts.pend) cmd.op = OP_PUSH;
          else          state_nxt = ST_MRD;
        end
      end
      ST_MRD: state_nxt = ST_MUPD;
      ST_MUPD: begin
        cmd.op = OP_MAP_UPD;
        if (sts.corner_last) state_nxt = sts.face_last ? ST_END : ST_KEY;
        else                 state_nxt = ST_MRD;
      end
      ST_END: begin
        if (!sts.out_busy) begin
          cmd.op    = sts.pend ? OP_FINAL : OP_ACK;
          cmd.ack   = STS_OK;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_RCLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RCLR;
      ack_r   <= STS_OK;
    end else begin
      state_r <= state_nxt;
      ack_r   <= ack_nxt;
    end
  end

endmodule

>>> design/tbfe_dp.sv
module tbfe_dp import tbfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  input  logic [1:0]       in_cmd,
  input  logic [VID_W-1:0] in_corner_a,
  input  logic [VID_W-1:0] in_corner_b,
  input  logic [VID_W-1:0] in_corner_c,
  input  logic [VID_W-1:0] in_corner_d,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             out_face_valid,
  output logic [VID_W-1:0] out_vol_a,
  output logic [VID_W-1:0] out_vol_b,
  output logic [VID_W-1:0] out_vol_c,
  output logic [VID_W-1:0] out_surf_a,
  output logic [VID_W-1:0] out_surf_b,
  output logic [VID_W-1:0] out_surf_c,
  output logic [2:0]       out_new_corners,
  output logic [1:0]       out_status,
  output logic             out_last
);

  // stores
  logic [4*VID_W-1:0] tmem [MAX_TETS];
  logic [KEY_W:0]     fmem [FACE_SLOTS];
  logic [VID_W:0]     vmem [VID_SPACE];
  logic [4*VID_W-1:0] tdat_r;
  logic [KEY_W:0]     fdat_r;
  logic [VID_W:0]     vdat_r;

  // item registers
  cmd_t             cmd_r;
  logic [VID_W-1:0] t_r [4];
  logic [KEY_W-1:0] key_r;

  // control registers
  logic [CNT_W-1:0]   tet_cnt_r, scan_ptr_r;
  logic [SVC_W-1:0]   svc_r;
  logic [FSLOT_W-1:0] clr_idx_r, slot_r;
  logic [1:0]         face_r, rot_r, corner_r;
  logic               pend_r, out_valid_r;

  // result registers
  logic             face_valid_r, last_r;
  logic [VID_W-1:0] vol_r [3];
  logic [VID_W-1:0] surf_r [3];
  logic [2:0]       new_r;
  logic [1:0]       status_r;

  logic [VID_W-1:0] v0, v1, v2, vcur, sid;
  logic [KEY_W-1:0] key_sel;
  logic             fresh;

  // corners of the current face
  assign v0 = t_r[face_corner(face_r, 2'd0)];
  assign v1 = t_r[face_corner(face_r, 2'd1)];
  assign v2 = t_r[face_corner(face_r, 2'd2)];

  // stored orientation on load, rotations of the reversed triple on scan
  always_comb begin
    if (cmd_r == CMD_LOAD) begin
      key_sel = {v0, v1, v2};
    end else begin
      unique case (rot_r)
        2'd0:    key_sel = {v0, v2, v1};
        2'd1:    key_sel = {v1, v0, v2};
        default: key_sel = {v2, v1, v0};
      endcase
    end
  end

  always_comb begin
    unique case (corner_r)
      2'd0:    vcur = v0;
      2'd1:    vcur = v1;
      default: vcur = v2;
    endcase
  end

  // renumber lookup
  assign fresh = !vdat_r[VID_W] && (svc_r < SVC_W'(MAX_VERTS));
  assign sid   = vdat_r[VID_W] ? vdat_r[VID_W-1:0] :
                 (fresh ? svc_r[VID_W-1:0] : '0);

  // status to controller
  assign sts.cmd         = cmd_r;
  assign sts.full        = (tet_cnt_r == CNT_W'(MAX_TETS));
  assign sts.scan_empty  = (scan_ptr_r >= tet_cnt_r);
  assign sts.slot_empty  = !fdat_r[KEY_W];
  assign sts.slot_hit    = (fdat_r[KEY_W-1:0] == key_r);
  assign sts.face_last   = (face_r == 2'd3);
  assign sts.rot_last    = (rot_r == 2'd2);
  assign sts.corner_last = (corner_r == 2'd2);
  assign sts.pend        = pend_r;
  assign sts.out_busy    = out_valid_r;
  assign sts.clr_done    = (clr_idx_r == {FSLOT_W{1'b1}});

  // tet store
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TET_WR) tmem[tet_cnt_r[TET_AW-1:0]] <= {t_r[3], t_r[2], t_r[1], t_r[0]};
    tdat_r <= tmem[scan_ptr_r[TET_AW-1:0]];
  end

  // face set, open addressing
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR_STEP)  fmem[clr_idx_r] <= '0;
    else if (cmd.op == OP_PINS) fmem[slot_r] <= {1'b1, key_r};
    fdat_r <= fmem[slot_r];
  end

  // vertex renumber map
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLR_STEP)
      vmem[clr_idx_r[VID_W-1:0]] <= '0;
    else if (cmd.op == OP_MAP_UPD && fresh)
      vmem[vcur] <= {1'b1, svc_r[VID_W-1:0]};
    vdat_r <= vmem[vcur];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tet_cnt_r   <= '0;
      scan_ptr_r  <= '0;
      svc_r       <= '0;
      clr_idx_r   <= '0;
      slot_r      <= '0;
      face_r      <= '0;
      rot_r       <= '0;
      corner_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_CLR_INIT: begin
          tet_cnt_r  <= '0;
          scan_ptr_r <= '0;
          svc_r      <= '0;
          clr_idx_r  <= '0;
        end
        OP_CLR_STEP: clr_idx_r <= clr_idx_r + 1'b1;
        OP_TET_WR: begin
          tet_cnt_r <= tet_cnt_r + 1'b1;
          face_r    <= '0;
          rot_r     <= '0;
        end
        OP_TET_LAT: begin
          scan_ptr_r <= scan_ptr_r + 1'b1;
          face_r     <= '0;
          rot_r      <= '0;
          corner_r   <= '0;
          pend_r     <= 1'b0;
        end
        OP_KEY:   slot_r <= face_home(key_sel);
        OP_PNEXT: slot_r <= slot_r + 1'b1;
        OP_PINS, OP_NEXT_FACE: begin
          face_r <= face_r + 1'b1;
          rot_r  <= '0;
        end
        OP_NEXT_ROT: rot_r <= rot_r + 1'b1;
        OP_MAP_UPD: begin
          if (fresh) svc_r <= svc_r + 1'b1;
          if (corner_r == 2'd2) begin
            corner_r <= '0;
            face_r   <= face_r + 1'b1;
            rot_r    <= '0;
            pend_r   <= 1'b1;
          end else begin
            corner_r <= corner_r + 1'b1;
          end
        end
        OP_PUSH, OP_FINAL: begin
          pend_r      <= 1'b0;
          out_valid_r <= 1'b1;
        end
        OP_ACK: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        cmd_r  <= cmd_t'(in_cmd);
        t_r[0] <= in_corner_a;
        t_r[1] <= in_corner_b;
        t_r[2] <= in_corner_c;
        t_r[3] <= in_corner_d;
      end
      OP_TET_LAT: begin
        t_r[0] <= tdat_r[VID_W-1:0];
        t_r[1] <= tdat_r[2*VID_W-1:VID_W];
        t_r[2] <= tdat_r[3*VID_W-1:2*VID_W];
        t_r[3] <= tdat_r[4*VID_W-1:3*VID_W];
      end
      OP_KEY: key_r <= key_sel;
      OP_MAP_UPD: begin
        face_valid_r     <= 1'b1;
        status_r         <= STS_OK;
        last_r           <= 1'b0;
        vol_r[corner_r]  <= vcur;
        surf_r[corner_r] <= sid;
        if (corner_r == 2'd0) new_r <= {2'b00, fresh};
        else                  new_r[corner_r] <= fresh;
      end
      OP_PUSH:  last_r <= 1'b0;
      OP_FINAL: last_r <= 1'b1;
      OP_ACK: begin
        face_valid_r <= 1'b0;
        vol_r[0]     <= '0;
        vol_r[1]     <= '0;
        vol_r[2]     <= '0;
        surf_r[0]    <= '0;
        surf_r[1]    <= '0;
        surf_r[2]    <= '0;
        new_r        <= '0;
        status_r     <= cmd.ack;
        last_r       <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_face_valid  = face_valid_r;
  assign out_vol_a       = vol_r[0];
  assign out_vol_b       = vol_r[1];
  assign out_vol_c       = vol_r[2];
  assign out_surf_a      = surf_r[0];
  assign out_surf_b      = surf_r[1];
  assign out_surf_c      = surf_r[2];
  assign out_new_corners = new_r;
  assign out_status      = status_r;
  assign out_last        = last_r;

endmodule

>>> design/tet_boundary_face_extractor_top.sv
// Tetrahedral boundary face extractor.
// Input channel (in_valid / in_stall): in_cmd clear, load or scan, plus four
// corner ids for a load. One item is worked on at a time; in_stall is low only
// while the controller is idle.
// Result channel (out_valid / out_stall): a load, clear or empty scan gives one
// item with last set; a scan gives one item per boundary face, last on the
// final one, or one item with face_valid low when the tet is fully inside.
// A load, unless the store is full, writes the tet, then for each of its four
// faces does a key step, a face-set read and a compare, with a further read and
// compare per extra probe step; the next item can be taken after the acknowledge.
// Scan: the stored tet is latched; then, per face, each rotation is looked up
// with a key step, a read and a compare, plus a read and compare per extra probe
// step. A boundary face adds the hand-off of the held face and three vertex-map
// read-modify-writes, and a final step issues the last item. Waits for the
// output register add to all of these. Reset and clear: a pass over all 8192
// face-set slots empties the face set and vertex map, during which in_stall
// stays high; the clear item is acknowledged after the pass. When the receiver
// stalls, the held result stays put; the next item is still accepted and runs
// until it needs the output register.
module tet_boundary_face_extractor_top import tbfe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [VID_W-1:0] in_corner_a,
  input  logic [VID_W-1:0] in_corner_b,
  input  logic [VID_W-1:0] in_corner_c,
  input  logic [VID_W-1:0] in_corner_d,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_face_valid,
  output logic [VID_W-1:0] out_vol_a,
  output logic [VID_W-1:0] out_vol_b,
  output logic [VID_W-1:0] out_vol_c,
  output logic [VID_W-1:0] out_surf_a,
  output logic [VID_W-1:0] out_surf_b,
  output logic [VID_W-1:0] out_surf_c,
  output logic [2:0]       out_new_corners,
  output logic [1:0]       out_status,
  output logic             out_last
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  tbfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  tbfe_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .in_cmd          (in_cmd),
    .in_corner_a     (in_corner_a),
    .in_corner_b     (in_corner_b),
    .in_corner_c     (in_corner_c),
    .in_corner_d     (in_corner_d),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_face_valid  (out_face_valid),
    .out_vol_a       (out_vol_a),
    .out_vol_b       (out_vol_b),
    .out_vol_c       (out_vol_c),
    .out_surf_a      (out_surf_a),
    .out_surf_b      (out_surf_b),
    .out_surf_c      (out_surf_c),
    .out_new_corners (out_new_corners),
    .out_status      (out_status),
    .out_last        (out_last)
  );

  // an accepted item holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // error acknowledges are always single final items
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STS_OK) |-> out_last && !out_face_valid)
    else $error("error result not final");

  // a face result never carries an error status
  a_face_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_face_valid |-> out_status == STS_OK)
    else $error("face result with error status");

endmodule
